/* sv/tpm_pkg.sv */
package tpm_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;

  localparam int TIME_W      = 48;
  localparam int HANDLE_W    = 16;
  localparam int CAP_W       = 6;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CAP_W-1:0]     CAP_RESET     = 6'd32;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CAP = 8'd1;

  typedef struct packed {
    logic [HANDLE_W-1:0] frame_handle;
    logic [TIME_W-1:0]   frame_time;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  // x is below 2*QUEUE_DEPTH, so one conditional subtract wraps it
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'(QUEUE_DEPTH);
    if (x >= lim) begin
      return PTR_W'(x - lim);
    end
    return PTR_W'(x);
  endfunction

  // zero acts as one, anything above the storage depth is clipped
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] r);
    if (r == '0) begin
      return CNT_W'(1);
    end
    if (32'(r) > QUEUE_DEPTH) begin
      return CNT_W'(QUEUE_DEPTH);
    end
    return CNT_W'(r);
  endfunction

endpackage

/* sv/tpm_ram.sv */
module tpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tpm_queue.sv */
// Cyclic frame queue: head/count pointers around one RAM.
// The RAM always reads at head; the read data is registered and shows up in the next cycle.
module tpm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  tpm_pkg::q_ctl_t        ctl,
  input  logic [tpm_pkg::CNT_W-1:0] cap,
  input  tpm_pkg::entry_t        wr_entry,
  output tpm_pkg::entry_t        head_entry,
  output logic                   nonempty
);

  logic [tpm_pkg::PTR_W-1:0] head, head_next;
  logic [tpm_pkg::CNT_W-1:0] count, count_next;
  logic [tpm_pkg::PTR_W-1:0] base_head, slot;
  logic [tpm_pkg::CNT_W-1:0] base_count, cap_m1;
  logic [$bits(tpm_pkg::entry_t)-1:0] rd_bits;

  always_comb begin
    cap_m1 = cap - tpm_pkg::CNT_W'(1);
    // make room: drop oldest until count is cap-1
    if (count >= cap) begin
      base_head  = tpm_pkg::wrap_ptr(tpm_pkg::SUM_W'(head)
                                     + tpm_pkg::SUM_W'(count - cap_m1));
      base_count = cap_m1;
    end else begin
      base_head  = head;
      base_count = count;
    end
    slot = tpm_pkg::wrap_ptr(tpm_pkg::SUM_W'(base_head) + tpm_pkg::SUM_W'(base_count));

    head_next  = head;
    count_next = count;
    if (ctl.push) begin
      head_next  = base_head;
      count_next = base_count + tpm_pkg::CNT_W'(1);
    end else if (ctl.pop && (count != '0)) begin
      head_next  = tpm_pkg::wrap_ptr(tpm_pkg::SUM_W'(head) + tpm_pkg::SUM_W'(1));
      count_next = count - tpm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  tpm_ram #(
    .WIDTH ($bits(tpm_pkg::entry_t)),
    .DEPTH (tpm_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (head),
    .rdata (rd_bits)
  );

  assign head_entry = tpm_pkg::entry_t'(rd_bits);
  assign nonempty   = (count != '0);

endmodule

/* sv/timestamp_pair_matcher_core.sv */
// Timestamp pair matcher. Each accepted word is one frame (stream flag in s_tuser,
// 48-bit timestamp and 16-bit handle in s_tdata); it is appended to the color or
// depth queue, then the queue heads are compared and the older head is dropped
// until both heads carry the same timestamp (pair reported, both popped) or a
// queue runs empty (no match). Exactly one result word per frame. A full queue
// overwrites its oldest entry. Items are handled one at a time: an accepted frame is
// pushed, then the heads are read and compared, again after each dropped head, and
// the result register is loaded in the done state, which waits while a previous
// result word still waits on m_tready. The next frame is taken the cycle after
// the result is loaded. The read-compare loop runs over the two queue RAMs, one
// head comparison per RAM read. Queue storage needs no clearing pass after reset.
// The user must write capacities through the cfg port only while the block is
// idle; the block itself does not enforce it. Index 0 color_capacity,
// index 1 depth_capacity.
module timestamp_pair_matcher_core (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [47:0] frame_time, [63:48] frame_handle
  input  logic        s_tuser,   // [0] is_depth

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] color_out, [31:16] depth_out
  output logic        m_tuser,   // [0] matched

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpm_pkg::CAP_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PUSH = 5'b00010,
    ST_RD   = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // capacity registers
  logic [tpm_pkg::CAP_W-1:0] color_capacity, depth_capacity;

  // latched input frame
  tpm_pkg::entry_t in_entry;
  logic            in_is_depth;

  // result being built
  logic                         res_matched;
  logic [tpm_pkg::HANDLE_W-1:0] res_color, res_depth;

  tpm_pkg::q_ctl_t color_ctl, depth_ctl;
  tpm_pkg::entry_t color_head, depth_head;
  logic            color_nonempty, depth_nonempty;

  logic out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_capacity <= tpm_pkg::CAP_RESET;
      depth_capacity <= tpm_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpm_pkg::CFG_COLOR_CAP: color_capacity <= cfg_data;
        tpm_pkg::CFG_DEPTH_CAP: depth_capacity <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // FSM and queue commands
  always_comb begin
    state_next = state;
    color_ctl  = '0;
    depth_ctl  = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        color_ctl.push = !in_is_depth;
        depth_ctl.push = in_is_depth;
        state_next     = ST_RD;
      end
      ST_RD: begin
        // RAMs are reading both heads this cycle
        if (color_nonempty && depth_nonempty) state_next = ST_CMP;
        else                                  state_next = ST_DONE;
      end
      ST_CMP: begin
        if (color_head.frame_time > depth_head.frame_time) begin
          depth_ctl.pop = 1'b1;
          state_next    = ST_RD;
        end else if (color_head.frame_time < depth_head.frame_time) begin
          color_ctl.pop = 1'b1;
          state_next    = ST_RD;
        end else begin
          color_ctl.pop = 1'b1;
          depth_ctl.pop = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_entry.frame_time   <= s_tdata[47:0];
      in_entry.frame_handle <= s_tdata[63:48];
      in_is_depth           <= s_tuser;
    end
  end

  // result build-up: cleared per frame, filled on an equal-time pair
  always_ff @(posedge clk) begin
    if (state == ST_PUSH) begin
      res_matched <= 1'b0;
      res_color   <= '0;
      res_depth   <= '0;
    end else if ((state == ST_CMP)
                 && (color_head.frame_time == depth_head.frame_time)) begin
      res_matched <= 1'b1;
      res_color   <= color_head.frame_handle;
      res_depth   <= depth_head.frame_handle;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {res_depth, res_color};
      m_tuser <= res_matched;
    end
  end

  tpm_queue u_color_q (
    .clk        (clk),
    .rst        (rst),
    .ctl        (color_ctl),
    .cap        (tpm_pkg::eff_cap(color_capacity)),
    .wr_entry   (in_entry),
    .head_entry (color_head),
    .nonempty   (color_nonempty)
  );

  tpm_queue u_depth_q (
    .clk        (clk),
    .rst        (rst),
    .ctl        (depth_ctl),
    .cap        (tpm_pkg::eff_cap(depth_capacity)),
    .wr_entry   (in_entry),
    .head_entry (depth_head),
    .nonempty   (depth_nonempty)
  );

endmodule

/* tb/tpm_checker.sv */
module tpm_checker
  import tpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [63:0]          s_tdata,   // [47:0] frame_time, [63:48] frame_handle
  input  logic                 s_tuser,   // [0] is_depth

  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // [15:0] color_out, [31:16] depth_out
  input  logic                 m_tuser,   // [0] matched

  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data,

  output int                   fail_count,
  output int                   pairs_owed,
  output int                   frames_seen,
  output int                   pairs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLOR_Q = 0;
  localparam int DEPTH_Q = 1;

  typedef struct packed {
    logic                matched;
    logic [HANDLE_W-1:0] color_h;
    logic [HANDLE_W-1:0] depth_h;
  } pair_result_t;

  logic [TIME_W-1:0]   stamp_mem  [2][QUEUE_DEPTH];
  logic [HANDLE_W-1:0] handle_mem [2][QUEUE_DEPTH];
  int                  q_head [2];
  int                  q_fill [2];
  logic [CAP_W-1:0]    cap_reg [2];

  pair_result_t        owed_results [$];
  pair_result_t        want;
  pair_result_t        fresh;

  initial begin
    fail_count  = 0;
    pairs_owed  = 0;
    frames_seen = 0;
    pairs_seen  = 0;
  end

  task automatic flag_error(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  // zero means one entry, anything past the storage depth is clipped
  function automatic int cap_limit(input logic [CAP_W-1:0] r);
    if (r == '0) begin
      return 1;
    end
    if (int'(r) > QUEUE_DEPTH) begin
      return QUEUE_DEPTH;
    end
    return int'(r);
  endfunction

  function automatic void drop_head(input int s);
    if (q_fill[s] != 0) begin
      q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
      q_fill[s]--;
    end
  endfunction

  // append the frame, then drain older heads until a pair or an empty queue
  function automatic pair_result_t predict_pair(input int s, input logic [TIME_W-1:0] stamp,
                                                input logic [HANDLE_W-1:0] handle);
    pair_result_t      res;
    int                slot;
    logic              done;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] dt;
    while (q_fill[s] >= cap_limit(cap_reg[s])) begin
      drop_head(s);
    end
    slot = (q_head[s] + q_fill[s]) % QUEUE_DEPTH;
    stamp_mem[s][slot]  = stamp;
    handle_mem[s][slot] = handle;
    q_fill[s]++;

    res  = '0;
    done = 1'b0;
    while (!done && q_fill[COLOR_Q] != 0 && q_fill[DEPTH_Q] != 0) begin
      ct = stamp_mem[COLOR_Q][q_head[COLOR_Q]];
      dt = stamp_mem[DEPTH_Q][q_head[DEPTH_Q]];
      if (ct > dt) begin
        drop_head(DEPTH_Q);
      end else if (ct < dt) begin
        drop_head(COLOR_Q);
      end else begin
        res.matched = 1'b1;
        res.color_h = handle_mem[COLOR_Q][q_head[COLOR_Q]];
        res.depth_h = handle_mem[DEPTH_Q][q_head[DEPTH_Q]];
        drop_head(COLOR_Q);
        drop_head(DEPTH_Q);
        done = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        q_head[s]  = 0;
        q_fill[s]  = 0;
        cap_reg[s] = CAP_RESET;
      end
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLOR_CAP) begin
          cap_reg[COLOR_Q] = cfg_data;
        end else if (cfg_index == CFG_DEPTH_CAP) begin
          cap_reg[DEPTH_Q] = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = predict_pair(s_tuser ? DEPTH_Q : COLOR_Q,
                             s_tdata[TIME_W-1:0],
                             s_tdata[TIME_W +: HANDLE_W]);
        owed_results = {owed_results, fresh};
        frames_seen++;
      end
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          flag_error($sformatf("result word with nothing owed: user=%0b data=%h",
                               m_tuser, m_tdata));
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (want.matched) begin
            pairs_seen++;
          end
          if (m_tuser !== want.matched) begin
            flag_error($sformatf("matched: got %b want %b", m_tuser, want.matched));
          end
          if (m_tdata[15:0] !== want.color_h) begin
            flag_error($sformatf("color_out: got %h want %h", m_tdata[15:0], want.color_h));
          end
          if (m_tdata[31:16] !== want.depth_h) begin
            flag_error($sformatf("depth_out: got %h want %h", m_tdata[31:16], want.depth_h));
          end
        end
      end
    end
    pairs_owed = owed_results.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import tpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // stream flag values carried in s_tuser
  localparam logic IS_COLOR = 1'b0;
  localparam logic IS_DEPTH = 1'b1;

  // indexes that map to no register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = 8'hFF;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 220;
  // covers a frame that drains both full queues, plus long random stalls on both sides
  localparam int STALL_LIMIT  = 5000;
  // settle time after the last owed word before touching config / ending
  localparam int DRAIN_CYCLES = 8;

  // per-segment capacity settings, segment 0 in the low bits;
  // covers reset value, one, zero (acts as one), 63 and 33 (both clip to depth)
  localparam logic [SEGMENTS*CAP_W-1:0] COLOR_CAPS =
    {6'd17, 6'd2, 6'd33, 6'd5, 6'd63, 6'd0, 6'd1, 6'd32};
  localparam logic [SEGMENTS*CAP_W-1:0] DEPTH_CAPS =
    {6'd4, 6'd8, 6'd32, 6'd1, 6'd0, 6'd63, 6'd3, 6'd32};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;    // [47:0] frame_time, [63:48] frame_handle
  logic                 s_tuser = 1'b0;  // [0] is_depth

  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;         // [15:0] color_out, [31:16] depth_out
  logic                 m_tuser;         // [0] matched

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAP_W-1:0]     cfg_data = '0;

  int                   fail_count;
  int                   pairs_owed;
  int                   frames_seen;
  int                   pairs_seen;

  // pacing knobs, percent of cycles spent idle on each side
  int                   src_idle_pct   = 0;
  int                   sink_stall_pct = 0;
  int                   cap_settings   = 0;
  int                   quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timestamp_pair_matcher_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpm_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pairs_owed  (pairs_owed),
    .frames_seen (frames_seen),
    .pairs_seen  (pairs_seen)
  );

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("timestamp_pair_matcher_core verification failed");
        $finish;
      end
    end
  end

  // one frame word; called and returns at a falling edge. Valid is only
  // dropped inside a gap, so back-to-back words keep it high.
  task automatic send_frame(input logic is_depth, input logic [TIME_W-1:0] stamp,
                            input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {handle, stamp};
    s_tuser  <= is_depth;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // register write; valid drops at the next falling edge and the task waits
  // once more before returning so a following write starts on a fresh edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait until every owed result word has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pairs_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_caps(input logic [CAP_W-1:0] color_cap, input logic [CAP_W-1:0] depth_cap);
    wait_idle();
    write_reg(CFG_COLOR_CAP, color_cap);
    write_reg(CFG_DEPTH_CAP, depth_cap);
    cap_settings++;
  endtask

  initial begin
    int                seg;
    int                sent;
    int                pick;
    int                run_len;
    int                kind;
    logic              first;
    logic [TIME_W-1:0] stamp;

    stamp = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part, reset capacities (32/32), no idling ----
    // lone color, then depth with equal stamp zero -> pair
    send_frame(IS_COLOR, '0, 16'h0000);
    send_frame(IS_DEPTH, '0, 16'hFFFF);
    // top stamp, depth first this time
    send_frame(IS_DEPTH, TIME_MAX, 16'h1234);
    send_frame(IS_COLOR, TIME_MAX, 16'hFFFF);
    // drain: color 5 dropped, depth 6 dropped, then 7/7 pairs
    send_frame(IS_COLOR, 48'd5, 16'h00A0);
    send_frame(IS_COLOR, 48'd7, 16'h00B0);
    send_frame(IS_DEPTH, 48'd6, 16'h00C0);
    send_frame(IS_DEPTH, 48'd7, 16'h00D0);

    // writes to indexes with no register must leave both capacities alone
    wait_idle();
    write_reg(CFG_NO_REG_HI, 6'd63);
    write_reg(CFG_NO_REG_LO, 6'd0);

    // zero capacity behaves as one: second color overwrites the first
    set_caps(6'd0, 6'd63);
    send_frame(IS_COLOR, 48'd10, 16'h0101);
    send_frame(IS_COLOR, 48'd11, 16'h0202);
    send_frame(IS_DEPTH, 48'd10, 16'h0303);
    send_frame(IS_DEPTH, 48'd11, 16'h0404);

    // fill color with four entries, then shrink capacity under it
    set_caps(6'd32, 6'd32);
    for (int i = 0; i < 4; i++) begin
      send_frame(IS_COLOR, 48'(20 + i), 16'(16'h1000 + i));
    end
    set_caps(6'd2, 6'd32);
    send_frame(IS_COLOR, 48'd24, 16'h1004);
    send_frame(IS_DEPTH, 48'd23, 16'h2003);

    // ---- random part: one capacity setting and pacing mode per segment ----
    for (seg = 0; seg < SEGMENTS; seg++) begin
      set_caps(COLOR_CAPS[seg*CAP_W +: CAP_W], DEPTH_CAPS[seg*CAP_W +: CAP_W]);
      case (seg % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 65;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 65;
        end
        default: begin
          src_idle_pct   = 23;
          sink_stall_pct = 23;
        end
      endcase

      sent = 0;
      while (sent < SEG_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // well-formed run: rising stamps, mostly present on both streams
          if ($urandom_range(7) == 0) begin
            stamp = {16'($urandom), 32'($urandom)};
          end
          run_len = $urandom_range(16, 4);
          repeat (run_len) begin
            stamp = stamp + 48'($urandom_range(3, 1));
            kind  = $urandom_range(9);
            if (kind <= 5) begin
              first = 1'($urandom);
              send_frame(first, stamp, 16'($urandom));
              send_frame(!first, stamp, 16'($urandom));
              sent += 2;
            end else begin
              send_frame((kind >= 8) ? IS_DEPTH : IS_COLOR, stamp, 16'($urandom));
              sent++;
            end
          end
        end else if (pick < 90) begin
          // late or repeated stamp on a random stream
          send_frame(1'($urandom), stamp - 48'($urandom_range(5)), 16'($urandom));
          sent++;
        end else begin
          // noise: any stamp at all
          send_frame(1'($urandom), {16'($urandom), 32'($urandom)}, 16'($urandom));
          sent++;
        end
      end
    end

    wait_idle();

    $display("run covered %0d frames, %0d of them reported as pairs", frames_seen, pairs_seen);
    $display("over %0d capacity settings and four pacing modes on both channels",
             cap_settings);
    if (fail_count == 0 && pairs_owed == 0) begin
      $display("timestamp_pair_matcher_core verification clean");
    end else begin
      $display("timestamp_pair_matcher_core verification failed");
    end
    $finish;
  end

endmodule
